>>> rtl/ple_pkg.sv
// Package for the positional list engine: opcodes, status codes, word types
// and the per-cell command type. Used by every module of the block.
`timescale 1ns / 1ps

package ple_pkg;

  // Opcodes of an input word.
  localparam logic [3:0] OP_APPEND     = 4'd0;
  localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
  localparam logic [3:0] OP_POP_BACK   = 4'd2;
  localparam logic [3:0] OP_POP_FRONT  = 4'd3;
  localparam logic [3:0] OP_INSERT     = 4'd4;
  localparam logic [3:0] OP_ERASE_POS  = 4'd5;
  localparam logic [3:0] OP_ERASE_VAL  = 4'd6;
  localparam logic [3:0] OP_FIND       = 4'd7;
  localparam logic [3:0] OP_READ       = 4'd8;
  localparam logic [3:0] OP_CLEAR      = 4'd9;
  localparam logic [3:0] OP_SORT       = 4'd10;

  // Status codes of a result word.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         found_position;
    logic signed [31:0] read_value;
    logic [5:0]         item_count;
    logic               is_empty;
  } out_word_t;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_RIGHT = 2'd2,
    SEL_LOAD  = 2'd3
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t          sel;
    logic signed [31:0] load;
  } cell_cmd_t;

endpackage

>>> rtl/ple_cell.sv
// One list cell: holds a single entry and trades it with its neighbors.
// Depends on ple_pkg for the cell command type.
`timescale 1ns / 1ps

module ple_cell import ple_pkg::*; (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic signed [31:0] left_entry,
  input  logic signed [31:0] right_entry,
  input  logic signed [31:0] key,
  output logic signed [31:0] entry,
  output logic               match,
  output logic               gt_right
);

  // Entry register: hold, shift from a neighbor or load a new value.
  always_ff @(posedge clk) begin
    case (cmd.sel)
      SEL_HOLD:  entry <= entry;
      SEL_LEFT:  entry <= left_entry;
      SEL_RIGHT: entry <= right_entry;
      SEL_LOAD:  entry <= cmd.load;
      default:   entry <= entry;
    endcase
  end

  // Local compares for search and for the transposition sort.
  assign match    = (entry == key);
  assign gt_right = (entry > right_entry);

endmodule

>>> rtl/positional_list_engine_top.sv
// Positional list engine: an ordered list held in a chain of cells.
// A word is taken only in the idle state, so one word is in flight at a time.
// It passes through the scan, apply and done states, and through the sort state
// for a sort of more than one entry. The next word is taken once the result is
// registered, while that result may still wait.
// Reset (rst, synchronous): the list is emptied; cell contents are not cleared.
`timescale 1ns / 1ps

module positional_list_engine_top import ple_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_word_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_word_t result
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_SORT,
    S_DONE
  } state_t;

  state_t             state;
  in_word_t           item_q;
  logic [CNT_W-1:0]   count;
  logic [DEPTH-1:0]   match_q;
  logic [CNT_W-1:0]   sort_cnt;
  out_word_t          res;

  logic signed [31:0] entries [DEPTH];
  logic [DEPTH-1:0]   match;
  logic [DEPTH-1:0]   gt_right;
  logic [DEPTH-1:0]   swap;
  logic [DEPTH-1:0]   rd_hit;
  cell_cmd_t          cmds [DEPTH];

  logic [CMP_W-1:0]   cnt_x;
  logic [CMP_W-1:0]   pos_x;
  logic               full;
  logic [DEPTH-1:0]   first;
  logic               hit;
  logic [IDX_W-1:0]   fidx;
  logic signed [31:0] rd_word;

  logic               do_ins;
  logic               do_del;
  logic [CMP_W-1:0]   tgt;
  logic [2:0]         status_next;
  logic [CNT_W-1:0]   count_next;
  logic [5:0]         found_next;
  logic signed [31:0] rd_next;

  assign item_ready = (state == S_IDLE);
  assign cnt_x      = CMP_W'(count);
  assign pos_x      = CMP_W'(item_q.position);
  assign full       = (cnt_x == CMP_W'(DEPTH));

  // Lowest matching cell, isolated with one wide add.
  assign first = match_q & (~match_q + DEPTH'(1));
  assign hit   = |match_q;

  always_comb begin
    fidx    = '0;
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (first[k]) fidx = fidx | IDX_W'(k);
      if (rd_hit[k]) rd_word = rd_word | entries[k];
    end
  end

  // Decode the held word into a cell edit, a new count and a result.
  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    tgt         = '0;
    status_next = ST_OK;
    count_next  = count;
    found_next  = '0;
    rd_next     = '0;
    case (item_q.opcode)
      OP_APPEND, OP_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          tgt        = (item_q.opcode == OP_APPEND) ? cnt_x : '0;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          do_del     = 1'b1;
          tgt        = (item_q.opcode == OP_POP_BACK) ? (cnt_x - CMP_W'(1)) : '0;
          count_next = count - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
          status_next = ST_BADPOS;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          tgt        = pos_x - CMP_W'(1);
          count_next = count + CNT_W'(1);
        end
      end
      OP_ERASE_POS: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          status_next = ST_BADPOS;
        end else begin
          do_del     = 1'b1;
          tgt        = pos_x - CMP_W'(1);
          count_next = count - CNT_W'(1);
        end
      end
      OP_ERASE_VAL: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (!hit) begin
          status_next = ST_NOTFOUND;
        end else begin
          do_del     = 1'b1;
          tgt        = CMP_W'(fidx);
          count_next = count - CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (!hit) begin
          status_next = ST_NOTFOUND;
        end else begin
          found_next = 6'(CMP_W'(fidx) + CMP_W'(1));
        end
      end
      OP_READ: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          status_next = ST_BADPOS;
        end else begin
          rd_next = rd_word;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // The chain of cells with per-cell steering.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_inner_l
      assign left_in = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
      assign swap[i]  = 1'b0;
    end else begin : g_inner_r
      assign right_in = entries[i+1];
      // Pair (i, i+1) swaps on this sort phase when out of order.
      assign swap[i]  = (state == S_SORT) && (1'(i % 2) == sort_cnt[0]) &&
                        (CMP_W'(i + 1) < cnt_x) && gt_right[i];
    end

    assign rd_hit[i] = (CMP_W'(i) == pos_x - CMP_W'(1));

    always_comb begin
      cmds[i].load = item_q.value;
      cmds[i].sel  = SEL_HOLD;
      if (state == S_APPLY) begin
        if (do_ins && CMP_W'(i) > tgt) begin
          cmds[i].sel = SEL_LEFT;
        end else if (do_ins && CMP_W'(i) == tgt) begin
          cmds[i].sel = SEL_LOAD;
        end else if (do_del && CMP_W'(i) >= tgt) begin
          cmds[i].sel = SEL_RIGHT;
        end
      end else if (swap[i]) begin
        cmds[i].sel = SEL_RIGHT;
      end else if (i > 0) begin
        if (swap[(i > 0) ? i - 1 : 0]) cmds[i].sel = SEL_LEFT;
      end
    end

    ple_cell u_cell (
      .clk         (clk),
      .cmd         (cmds[i]),
      .left_entry  (left_in),
      .right_entry (right_in),
      .key         (item_q.value),
      .entry       (entries[i]),
      .match       (match[i]),
      .gt_right    (gt_right[i])
    );
  end

  // Sequencer, count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      sort_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      // The done state sets valid itself when it hands over a new word.
      if (result_valid && result_ready && state != S_DONE) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_q <= item;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          for (int k = 0; k < DEPTH; k++) begin
            match_q[k] <= match[k] && (CMP_W'(k) < cnt_x);
          end
          state <= S_APPLY;
        end
        S_APPLY: begin
          count              <= count_next;
          res.status         <= status_next;
          res.found_position <= found_next;
          res.read_value     <= rd_next;
          res.item_count     <= 6'(count_next);
          res.is_empty       <= (count_next == '0);
          sort_cnt           <= '0;
          if (item_q.opcode == OP_SORT && count > CNT_W'(1)) begin
            state <= S_SORT;
          end else begin
            state <= S_DONE;
          end
        end
        S_SORT: begin
          sort_cnt <= sort_cnt + CNT_W'(1);
          if (sort_cnt == CNT_W'(DEPTH - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/positional_list_engine_top_tb.sv
// Self-checking testbench for positional_list_engine_top: a directed table of list
// operations, then weighted random traffic; each result is checked against a list
// model or a typed table row's expected word. Depends on ple_pkg and the engine RTL only.
`timescale 1ns / 1ps

module positional_list_engine_top_tb;
  import ple_pkg::*;

  localparam int DEPTH = 32;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int PHASE_COUNT = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = DEPTH + 16;
  localparam logic [3:0] OP_UNUSED_TOP = 4'd15;

  // One row of the directed table; typed rows carry their expected result word.
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t exp;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_word_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_word_t result;

  // List model state.
  logic signed [31:0] list_mem [DEPTH];
  int                 list_len = 0;

  out_word_t pending_results [$];
  int        error_count = 0;
  int        quiet_cycles = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  bit        hold_off_request = 1'b0;

  dir_row_t  directed_rows [25];

  int phase_idle  [PHASE_COUNT] = '{0, 52, 0, 24, 0, 52, 0, 24};
  int phase_stall [PHASE_COUNT] = '{0, 0, 52, 24, 0, 0, 52, 24};
  int phase_push  [PHASE_COUNT] = '{30, 55, 30, 30, 55, 30, 55, 30};

  positional_list_engine_top #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shift entries up from the given slot and place the new value there.
  function automatic void open_slot(input int at, input logic signed [31:0] v);
    int i;
    for (i = list_len; i > at; i--) list_mem[i] = list_mem[i - 1];
    list_mem[at] = v;
    list_len++;
  endfunction

  // Remove the entry at the given slot and close the hole.
  function automatic void close_slot(input int at);
    int i;
    for (i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
    list_len--;
  endfunction

  // 1-based position of the first entry equal to v, or 0.
  function automatic int first_hit(input logic signed [31:0] v);
    int i;
    for (i = 0; i < list_len; i++) begin
      if (list_mem[i] == v) return i + 1;
    end
    return 0;
  endfunction

  // Apply one list operation to the model and return the result word it produces.
  function automatic out_word_t apply_list_op(input in_word_t w);
    out_word_t          r;
    int                 pos;
    int                 hit;
    int                 i;
    int                 j;
    logic signed [31:0] key;
    r = '0;
    pos = w.position;
    case (w.opcode)
      OP_APPEND, OP_PUSH_FRONT: begin
        if (list_len >= DEPTH) r.status = ST_FULL;
        else open_slot((w.opcode == OP_APPEND) ? list_len : 0, w.value);
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else close_slot((w.opcode == OP_POP_BACK) ? list_len - 1 : 0);
      end
      OP_INSERT: begin
        // Position is checked before fullness.
        if (pos < 1 || pos > list_len + 1) r.status = ST_BADPOS;
        else if (list_len >= DEPTH) r.status = ST_FULL;
        else open_slot(pos - 1, w.value);
      end
      OP_ERASE_POS: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else if (pos < 1 || pos > list_len) r.status = ST_BADPOS;
        else close_slot(pos - 1);
      end
      OP_ERASE_VAL: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = first_hit(w.value);
          if (hit == 0) r.status = ST_NOTFOUND;
          else close_slot(hit - 1);
        end
      end
      OP_FIND: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = first_hit(w.value);
          r.found_position = hit[5:0];
          if (hit == 0) r.status = ST_NOTFOUND;
        end
      end
      OP_READ: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else if (pos < 1 || pos > list_len) r.status = ST_BADPOS;
        else r.read_value = list_mem[pos - 1];
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      OP_SORT: begin
        // Ascending signed order.
        for (i = 1; i < list_len; i++) begin
          key = list_mem[i];
          j = i;
          while (j > 0 && key < list_mem[j - 1]) begin
            list_mem[j] = list_mem[j - 1];
            j--;
          end
          list_mem[j] = key;
        end
      end
      default: begin
      end
    endcase
    r.item_count = list_len[5:0];
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  function automatic dir_row_t dir_row(input logic [3:0] op, input logic signed [31:0] v,
                                       input logic [5:0] p, input bit typed,
                                       input logic [2:0] st, input logic [5:0] cnt);
    dir_row_t row;
    row.w = '{opcode: op, value: v, position: p};
    row.typed = typed;
    row.exp = '{status: st, found_position: 6'd0, read_value: 32'sd0,
                item_count: cnt, is_empty: (cnt == 6'd0)};
    return row;
  endfunction

  // Random word: pushes weighted by push_pct, values partly drawn from the list itself.
  function automatic in_word_t random_list_op(input int push_pct);
    in_word_t w;
    int       roll;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      w.opcode = $urandom_range(1) ? OP_APPEND : OP_PUSH_FRONT;
    end else if (roll < 97) begin
      w.opcode = 4'($urandom_range(OP_POP_BACK, OP_SORT));
      // A clear wipes the list, so keep it rare.
      if (w.opcode == OP_CLEAR && $urandom_range(5) != 0) w.opcode = OP_FIND;
    end else begin
      w.opcode = 4'($urandom_range(OP_UNUSED_TOP));
    end
    roll = $urandom_range(9);
    if (roll < 4 && list_len > 0) w.value = list_mem[$urandom_range(list_len - 1)];
    else if (roll < 6) w.value = $signed(32'($urandom_range(7))) - 32'sd4;
    else if (roll == 6) begin
      case ($urandom_range(3))
        0: w.value = 32'sh80000000;
        1: w.value = 32'sh7FFFFFFF;
        2: w.value = 32'sd0;
        default: w.value = -32'sd1;
      endcase
    end else w.value = $signed($urandom);
    if ($urandom_range(9) < 8) w.position = 6'($urandom_range(list_len + 1, 1));
    else w.position = 6'($urandom_range(63));
    return w;
  endfunction

  // Offer one word, wait for it to be taken, then record the expected result.
  task automatic offer_word(input in_word_t w, input bit typed, input out_word_t typed_exp);
    out_word_t predicted;
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    item <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predicted = apply_list_op(w);
    pending_results.insert(pending_results.size(), typed ? typed_exp : predicted);
  endtask

  // Result side: random stalls, or one long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $error("result word arrived with no expectation pending");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            error_count++;
          end
          if (result.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, result.found_position);
            error_count++;
          end
          if (result.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, result.read_value);
            error_count++;
          end
          if (result.item_count !== want.item_count) begin
            $error("item_count: expected %0d, got %0d", want.item_count, result.item_count);
            error_count++;
          end
          if (result.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, result.is_empty);
            error_count++;
          end
        end
      end
      if ((result_valid && result_ready) || (item_valid && item_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    int        p;
    int        n;
    out_word_t unused_exp;
    unused_exp = '0;
    directed_rows = '{
      dir_row(OP_POP_BACK,   32'sd0,           6'd0,  1'b1, ST_EMPTY,    6'd0),
      dir_row(OP_POP_FRONT,  32'sd0,           6'd0,  1'b1, ST_EMPTY,    6'd0),
      dir_row(OP_ERASE_POS,  32'sd0,           6'd1,  1'b1, ST_EMPTY,    6'd0),
      dir_row(OP_ERASE_VAL,  32'sd0,           6'd0,  1'b1, ST_EMPTY,    6'd0),
      dir_row(OP_FIND,       32'sd0,           6'd0,  1'b1, ST_EMPTY,    6'd0),
      dir_row(OP_READ,       32'sd0,           6'd1,  1'b1, ST_EMPTY,    6'd0),
      dir_row(OP_CLEAR,      32'sd0,           6'd0,  1'b1, ST_OK,       6'd0),
      dir_row(OP_SORT,       32'sd0,           6'd0,  1'b1, ST_OK,       6'd0),
      dir_row(OP_INSERT,     32'sd5,           6'd0,  1'b1, ST_BADPOS,   6'd0),
      dir_row(OP_INSERT,     32'sd5,           6'd2,  1'b1, ST_BADPOS,   6'd0),
      dir_row(OP_APPEND,     32'sh7FFFFFFF,    6'd0,  1'b1, ST_OK,       6'd1),
      dir_row(OP_PUSH_FRONT, 32'sh80000000,    6'd63, 1'b1, ST_OK,       6'd2),
      dir_row(OP_INSERT,     -32'sd1,          6'd3,  1'b0, ST_OK,       6'd0),
      dir_row(OP_INSERT,     32'sd7,           6'd63, 1'b1, ST_BADPOS,   6'd3),
      dir_row(OP_READ,       32'sd0,           6'd2,  1'b0, ST_OK,       6'd0),
      dir_row(OP_READ,       32'sd0,           6'd0,  1'b1, ST_BADPOS,   6'd3),
      dir_row(OP_READ,       32'sd0,           6'd4,  1'b1, ST_BADPOS,   6'd3),
      dir_row(OP_FIND,       -32'sd1,          6'd0,  1'b0, ST_OK,       6'd0),
      dir_row(OP_FIND,       32'sd12345,       6'd0,  1'b1, ST_NOTFOUND, 6'd3),
      dir_row(OP_ERASE_VAL,  32'sd12345,       6'd0,  1'b1, ST_NOTFOUND, 6'd3),
      dir_row(OP_SORT,       32'sd0,           6'd0,  1'b0, ST_OK,       6'd0),
      dir_row(OP_ERASE_POS,  32'sd0,           6'd4,  1'b1, ST_BADPOS,   6'd3),
      dir_row(OP_ERASE_POS,  32'sd0,           6'd2,  1'b0, ST_OK,       6'd0),
      dir_row(OP_UNUSED_TOP, 32'shFFFFFFFF,    6'd63, 1'b1, ST_OK,       6'd2),
      dir_row(OP_CLEAR,      32'sd0,           6'd0,  1'b1, ST_OK,       6'd0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].exp);
    end

    for (p = 0; p < PHASE_COUNT; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      // Hold the result side off for a long stretch at the start of this phase.
      if (p == 4) hold_off_request = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        offer_word(random_list_op(phase_push[p]), 1'b0, unused_exp);
      end
    end
    item_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
